### rtl/core/ttsup_pkg.sv
// Shared types and constants for the throttle torque supervisor.
package ttsup_pkg;

	// Drive mode as reported on run_mode
	typedef enum logic [1:0] {
		MODE_STOP  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_ERROR = 2'd2
	} mode_t;

	// Mode request codes carried with each tick
	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_STOP  = 2'd1,
		REQ_RUN   = 2'd2,
		REQ_ERROR = 2'd3
	} req_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_MAX_TORQUE   = 3'd0,
		CFG_MAX_SPEED    = 3'd1,
		CFG_LOW_VOLTAGE  = 3'd2,
		CFG_EMPTY_VOLT   = 3'd3,
		CFG_LOW_LIMIT    = 3'd4,
		CFG_EMPTY_LIMIT  = 3'd5,
		CFG_IDLE_LIMIT   = 3'd6,
		CFG_UNUSED       = 3'd7
	} cfg_idx_t;

	// Division by 1000 done as multiply by ceil(2^36/1000) and shift by 36.
	// Exact for products below 2^26 (max_torque * |throttle| <= 65535*1024).
	localparam int          DIV_SHIFT = 36;
	localparam logic [26:0] DIV_K     = 27'd68719477;

	// max_torque pre-scaled by DIV_K, and the product with |throttle|
	typedef logic [42:0] mtk_t;
	typedef logic [53:0] prod_t;

	localparam logic [15:0] TORQUE_SAT = 16'hFFFF;
	localparam logic [16:0] IDLE_MAX   = 17'h1FFFF;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_LOW_VOLTAGE = 16'd35000;
	localparam logic [15:0] RST_EMPTY_VOLT  = 16'd33000;
	localparam logic [7:0]  RST_LOW_LIMIT   = 8'd100;
	localparam logic [7:0]  RST_EMPTY_LIMIT = 8'd200;
	localparam logic [15:0] RST_IDLE_LIMIT  = 16'd6000;

endpackage

### rtl/core/ttsup_torque.sv
// Torque command: max_torque * throttle / 1000, truncated, saturated, forward torque low-battery gated.
module ttsup_torque (
	input  ttsup_pkg::mtk_t     mt_k,
	input  logic signed [10:0]  throttle,
	input  logic                low_batt,
	output logic signed [16:0]  torque
);

	logic [10:0]        mag;
	ttsup_pkg::prod_t   prod;
	logic [17:0]        quot;
	logic [15:0]        sat;

	// Magnitude of throttle; -1024 wraps to 1024 as unsigned, which is correct
	assign mag  = throttle[10] ? 11'(-throttle) : 11'(throttle);

	// Reciprocal multiply, quotient from the top bits
	assign prod = ttsup_pkg::prod_t'(mt_k) * ttsup_pkg::prod_t'(mag);
	assign quot = prod[53:ttsup_pkg::DIV_SHIFT];
	assign sat  = (quot > 18'(ttsup_pkg::TORQUE_SAT)) ? ttsup_pkg::TORQUE_SAT : quot[15:0];

	// Reverse torque is never gated; forward torque drops to zero on low battery
	always_comb begin
		if (throttle[10]) begin
			torque = -$signed({1'b0, sat});
		end else if (low_batt) begin
			torque = '0;
		end else begin
			torque = $signed({1'b0, sat});
		end
	end

endmodule

### rtl/core/throttle_torque_supervisor_core.sv
// Top level of the throttle torque supervisor: config registers, tick logic, result register.
//
// One input beat per control tick on s_t*: bus voltage, throttle, button and mode request.
// One result beat per tick on m_t*: torque command, mode, low-battery flag, power hold and
// the drive start/stop pulses. Configuration goes through cfg_we/cfg_index/cfg_wdata.
// The user must write it while no tick is in flight; the block does not enforce this.
// Indexes past the register list are ignored. A beat is registered on acceptance, then
// evaluated against the supervisor state into the output register when that is free or
// draining. Throughput is one beat per cycle while m_tready is high; the input stage and
// output register are separate, so a new beat is taken while a result waits. When m_tready
// stays low the result holds, the input stage fills, and s_tready drops until it is taken.
// Reset clears the mode to stop, all counters and flags, the shutdown state, and loads the
// configuration defaults. After a shutdown tick the block answers every later tick with
// power_hold low, zero torque and no pulses, mode and low-battery flag frozen.
// The torque path is one 43x11 multiply against max_torque prescaled by the reciprocal of
// 1000; the prescaled value is refreshed on each max_torque write.
module throttle_torque_supervisor_core (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // bus_voltage_mv[15:0], throttle[26:16], button_pressed[27],
	                               // mode_request[29:28], zero[31:30]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // torque_cmd[16:0], run_mode[18:17], low_battery[19],
	                               // power_hold[20], drive_start[21], drive_stop[22], zero[23]
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Configuration
	ttsup_pkg::mtk_t mt_k_q;
	logic [15:0] max_speed_q;
	logic [15:0] low_volt_q;
	logic [15:0] empty_volt_q;
	logic [7:0]  low_limit_q;
	logic [7:0]  empty_limit_q;
	logic [15:0] idle_limit_q;

	// Input stage
	logic               valid_s1;
	logic [15:0]        volt_s1;
	logic signed [10:0] thr_s1;
	logic               btn_s1;
	ttsup_pkg::req_t    req_s1;

	// Supervisor state
	ttsup_pkg::mode_t mode_q;
	logic        flag_q;
	logic [7:0]  low_cnt_q;
	logic [7:0]  empty_cnt_q;
	logic [16:0] idle_cnt_q;
	logic        halted_q;

	// Next state
	ttsup_pkg::mode_t mode_n;
	logic        flag_n;
	logic [7:0]  low_cnt_n;
	logic [7:0]  empty_cnt_n;
	logic [16:0] idle_cnt_n;
	logic [16:0] idle_base;
	logic        down;
	logic        start_n;
	logic        stop_n;
	logic signed [16:0] torque_raw;
	logic signed [16:0] torque_n;

	// Result register
	logic               out_valid_q;
	logic signed [16:0] torque_q;
	ttsup_pkg::mode_t   run_mode_q;
	logic               low_batt_q;
	logic               power_q;
	logic               start_q;
	logic               stop_q;

	logic advance;

	// Handshake: the input stage moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration registers; max_torque is kept prescaled for the divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_k_q        <= '0;
			max_speed_q   <= '0;
			low_volt_q    <= ttsup_pkg::RST_LOW_VOLTAGE;
			empty_volt_q  <= ttsup_pkg::RST_EMPTY_VOLT;
			low_limit_q   <= ttsup_pkg::RST_LOW_LIMIT;
			empty_limit_q <= ttsup_pkg::RST_EMPTY_LIMIT;
			idle_limit_q  <= ttsup_pkg::RST_IDLE_LIMIT;
		end else if (cfg_we) begin
			case (ttsup_pkg::cfg_idx_t'(cfg_index))
				ttsup_pkg::CFG_MAX_TORQUE: begin
					mt_k_q <= ttsup_pkg::mtk_t'(cfg_wdata) * ttsup_pkg::mtk_t'(ttsup_pkg::DIV_K);
				end
				ttsup_pkg::CFG_MAX_SPEED:   max_speed_q   <= cfg_wdata;
				ttsup_pkg::CFG_LOW_VOLTAGE: low_volt_q    <= cfg_wdata;
				ttsup_pkg::CFG_EMPTY_VOLT:  empty_volt_q  <= cfg_wdata;
				ttsup_pkg::CFG_LOW_LIMIT:   low_limit_q   <= cfg_wdata[7:0];
				ttsup_pkg::CFG_EMPTY_LIMIT: empty_limit_q <= cfg_wdata[7:0];
				ttsup_pkg::CFG_IDLE_LIMIT:  idle_limit_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage: payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			volt_s1 <= s_tdata[15:0];
			thr_s1  <= $signed(s_tdata[26:16]);
			btn_s1  <= s_tdata[27];
			req_s1  <= ttsup_pkg::req_t'(s_tdata[29:28]);
		end
	end

	// Torque for this tick, using the updated low-battery flag
	ttsup_torque u_torque (
		.mt_k     (mt_k_q),
		.throttle (thr_s1),
		.low_batt (flag_n),
		.torque   (torque_raw)
	);

	// Tick evaluation: request, voltage counters, idle check
	always_comb begin
		mode_n      = mode_q;
		flag_n      = flag_q;
		low_cnt_n   = low_cnt_q;
		empty_cnt_n = empty_cnt_q;
		idle_cnt_n  = idle_cnt_q;
		idle_base   = idle_cnt_q;
		down        = 1'b0;
		start_n     = 1'b0;
		stop_n      = 1'b0;
		if (!halted_q) begin
			case (req_s1)
				ttsup_pkg::REQ_RUN: begin
					if (thr_s1 == 11'sd0) begin
						mode_n  = ttsup_pkg::MODE_RUN;
						start_n = 1'b1;
					end
				end
				ttsup_pkg::REQ_STOP: begin
					mode_n = ttsup_pkg::MODE_STOP;
					stop_n = 1'b1;
				end
				ttsup_pkg::REQ_ERROR: begin
					mode_n = ttsup_pkg::MODE_ERROR;
					stop_n = 1'b1;
				end
				default: ;
			endcase

			// low counter with flag hysteresis at both ends
			if (volt_s1 < low_volt_q) begin
				if (low_cnt_q >= low_limit_q) begin
					low_cnt_n = low_limit_q;
					flag_n    = 1'b1;
				end else begin
					low_cnt_n = low_cnt_q + 8'd1;
				end
			end else if (low_cnt_q == 8'd0) begin
				flag_n = 1'b0;
			end else begin
				low_cnt_n = low_cnt_q - 8'd1;
			end

			// empty counter; past its limit the block shuts down
			if (volt_s1 < empty_volt_q) begin
				if (empty_cnt_q >= empty_limit_q) begin
					down = 1'b1;
				end else begin
					empty_cnt_n = empty_cnt_q + 8'd1;
				end
			end else if (empty_cnt_q != 8'd0) begin
				empty_cnt_n = empty_cnt_q - 8'd1;
			end

			// idle check, then clear on activity and count
			if (!down) begin
				if (idle_cnt_q > {1'b0, idle_limit_q}) begin
					down = 1'b1;
				end else begin
					if (thr_s1 != 11'sd0 || btn_s1) begin
						idle_base = '0;
					end
					idle_cnt_n = (idle_base == ttsup_pkg::IDLE_MAX) ? idle_base
					                                                : idle_base + 17'd1;
				end
			end
		end
	end

	// Torque only leaves the block in run mode on a live tick
	assign torque_n = (!halted_q && !down && mode_n == ttsup_pkg::MODE_RUN) ? torque_raw : '0;

	// State update once per evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ttsup_pkg::MODE_STOP;
			flag_q      <= 1'b0;
			low_cnt_q   <= '0;
			empty_cnt_q <= '0;
			idle_cnt_q  <= '0;
			halted_q    <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_n;
			flag_q      <= flag_n;
			low_cnt_q   <= low_cnt_n;
			empty_cnt_q <= empty_cnt_n;
			idle_cnt_q  <= idle_cnt_n;
			halted_q    <= halted_q | down;
		end
	end

	// Result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			torque_q   <= torque_n;
			run_mode_q <= mode_n;
			low_batt_q <= flag_n;
			power_q    <= !(halted_q || down);
			start_q    <= start_n;
			stop_q     <= stop_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, stop_q, start_q, power_q, low_batt_q, run_mode_q, torque_q};

	// max_speed is held for the drive side; no result field carries it
	logic unused_speed;
	assign unused_speed = ^max_speed_q;

endmodule
